// ----- rtl/radix2_fft_forward_inverse_unit_assert.svh -----
// ----------------------------------------------------------------------------
// radix2 fft assertion macros
// shorthand for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef RADIX2_FFT_FORWARD_INVERSE_UNIT_ASSERT_SVH
`define RADIX2_FFT_FORWARD_INVERSE_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define R2FFT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent in a cycle forces consequent in the same cycle
`define R2FFT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/r2fft_pkg.sv -----
// ----------------------------------------------------------------------------
// r2fft_pkg
// shared sizes, port structs, state codes and twiddle/bit-reverse functions
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int POINTS      = 64;
  localparam int LOG2_POINTS = $clog2(POINTS);
  localparam int ADDR_W      = LOG2_POINTS;
  localparam int STG_W       = (LOG2_POINTS > 1) ? $clog2(LOG2_POINTS) : 1;
  localparam int BF_W        = (LOG2_POINTS > 1) ? LOG2_POINTS - 1 : 1;
  localparam int SAMPLE_W    = 16;
  localparam int BIN_W       = 27;
  localparam int WORD_W      = 2 * BIN_W;
  localparam int TW_W        = 17;
  localparam int PROD_W      = BIN_W + TW_W;
  localparam int Z_W         = BIN_W + 1;
  localparam int RND_BITS    = 15;

  // write from the loader into the bank it fills
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } front_wr_t;

  // memory access of the butterfly engine
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } back_mem_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RD_TOP,
    B_RD_BOT,
    B_MUL,
    B_SUM,
    B_WR_TOP,
    B_WR_BOT,
    B_UNLOAD,
    B_DRAIN
  } back_state_t;

  // bit-reversed address for decimation in time
  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) begin
      r[b] = a[ADDR_W-1-b];
    end
    return r;
  endfunction

  // round(32768*cos(2*pi*t/64)) over the first quarter
  function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] t);
    logic signed [TW_W-1:0] v;
    case (t)
      5'd0:    v = 17'sd32768;
      5'd1:    v = 17'sd32610;
      5'd2:    v = 17'sd32138;
      5'd3:    v = 17'sd31357;
      5'd4:    v = 17'sd30274;
      5'd5:    v = 17'sd28899;
      5'd6:    v = 17'sd27246;
      5'd7:    v = 17'sd25330;
      5'd8:    v = 17'sd23170;
      5'd9:    v = 17'sd20788;
      5'd10:   v = 17'sd18205;
      5'd11:   v = 17'sd15447;
      5'd12:   v = 17'sd12540;
      5'd13:   v = 17'sd9512;
      5'd14:   v = 17'sd6393;
      5'd15:   v = 17'sd3212;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TW_W-1:0] tw_cos(input logic [4:0] t);
    logic signed [TW_W-1:0] v;
    if (t <= 5'd16) begin
      v = quarter_cos(t);
    end else begin
      v = -quarter_cos(5'(6'd32 - {1'b0, t}));
    end
    return v;
  endfunction

  function automatic logic signed [TW_W-1:0] tw_sin(input logic [4:0] t);
    logic signed [TW_W-1:0] v;
    if (t <= 5'd16) begin
      v = quarter_cos(5'(5'd16 - t));
    end else begin
      v = quarter_cos(5'(t - 5'd16));
    end
    return v;
  endfunction

endpackage

// ----- rtl/r2fft_ram.sv -----
// ----------------------------------------------------------------------------
// r2fft_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/r2fft_front.sv -----
// ----------------------------------------------------------------------------
// r2fft_front
// sample loader: counts words of a frame and stores them bit-reversed
// ----------------------------------------------------------------------------
module r2fft_front import r2fft_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_re,
  input  logic signed [SAMPLE_W-1:0] sample_im,
  output front_wr_t                  wr,
  output logic                       frame_done
);

  logic              accept;
  logic [ADDR_W-1:0] load_count;

  assign accept = push & ~full;

  // sign-extended sample into the bank being filled
  always_comb begin
    wr.en   = accept;
    wr.addr = bit_rev(load_count);
    wr.data = {{(BIN_W-SAMPLE_W){sample_re[SAMPLE_W-1]}}, sample_re,
               {(BIN_W-SAMPLE_W){sample_im[SAMPLE_W-1]}}, sample_im};
  end

  assign frame_done = accept && (load_count == ADDR_W'(POINTS - 1));

  // frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (accept) begin
      load_count <= frame_done ? '0 : load_count + 1'b1;
    end
  end

endmodule

// ----- rtl/r2fft_back.sv -----
// ----------------------------------------------------------------------------
// r2fft_back
// butterfly engine over one bank, then in-order unload into a two-word queue
// ----------------------------------------------------------------------------
module r2fft_back import r2fft_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    tok_valid,
  input  logic                    tok_mode,
  input  logic [WORD_W-1:0]       rdata,
  output back_mem_t               mem,
  output logic                    frame_end,
  input  logic                    pop,
  output logic                    empty,
  output logic signed [BIN_W-1:0] bin_re,
  output logic signed [BIN_W-1:0] bin_im,
  output logic                    bin_last
);

  back_state_t state, state_next;

  logic [STG_W-1:0] stage;
  logic [BF_W-1:0]  bf;
  logic [ADDR_W-1:0] k;
  logic             mode;
  logic             inflight, inflight_last, issue;

  logic signed [BIN_W-1:0]  a_re, a_im;
  logic signed [PROD_W-1:0] pr_rr, pr_ii, pr_ri, pr_ir;
  logic signed [Z_W-1:0]    z_re, z_im;

  // output queue
  logic signed [BIN_W-1:0] q_re [2];
  logic signed [BIN_W-1:0] q_im [2];
  logic                    q_last [2];
  logic                    q_wp, q_rp;
  logic [1:0]              q_count, occ;
  logic                    q_pop;

  // butterfly addressing for the current stage
  logic [ADDR_W-1:0] bfx, half, i_idx, top_addr, bot_addr;
  logic [STG_W:0]    stage_p1;
  logic [2:0]        tw_sh;
  logic [5:0]        tw_wide;
  logic [4:0]        tw_t;
  logic              bf_last, stage_last;

  always_comb begin
    bfx      = ADDR_W'(bf);
    half     = ADDR_W'(1) << stage;
    i_idx    = bfx & (half - 1'b1);
    stage_p1 = {1'b0, stage} + 1'b1;
    top_addr = ((bfx >> stage) << stage_p1) | i_idx;
    bot_addr = top_addr | half;
    tw_sh    = 3'd5 - 3'(stage);
    tw_wide  = 6'(i_idx) << tw_sh;
    tw_t     = tw_wide[4:0];
    bf_last    = (bf == BF_W'(POINTS / 2 - 1));
    stage_last = (stage == STG_W'(LOG2_POINTS - 1));
  end

  // twiddle, conjugated in inverse mode
  logic signed [TW_W-1:0] w_re, w_sin, w_im;
  assign w_re  = tw_cos(tw_t);
  assign w_sin = tw_sin(tw_t);
  assign w_im  = mode ? w_sin : -w_sin;

  logic signed [BIN_W-1:0] rd_re, rd_im;
  assign rd_re = rdata[WORD_W-1:BIN_W];
  assign rd_im = rdata[BIN_W-1:0];

  // rounded twiddle product sums
  logic signed [PROD_W:0] sum_r, sum_i, rnd_r, rnd_i;
  always_comb begin
    sum_r = {pr_rr[PROD_W-1], pr_rr} - {pr_ii[PROD_W-1], pr_ii};
    sum_i = {pr_ri[PROD_W-1], pr_ri} + {pr_ir[PROD_W-1], pr_ir};
    rnd_r = sum_r + (PROD_W+1)'(1 << (RND_BITS - 1));
    rnd_i = sum_i + (PROD_W+1)'(1 << (RND_BITS - 1));
  end

  // butterfly outputs
  logic signed [Z_W-1:0] top_re, top_im, bot_re, bot_im;
  always_comb begin
    top_re = a_re + z_re;
    top_im = a_im + z_im;
    bot_re = a_re - z_re;
    bot_im = a_im - z_im;
  end

  assign occ   = q_count + {1'b0, inflight};
  assign q_pop = pop && (q_count != 2'd0);

  // next state and memory control
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    frame_end  = 1'b0;
    mem.we     = 1'b0;
    mem.waddr  = top_addr;
    mem.wdata  = {top_re[BIN_W-1:0], top_im[BIN_W-1:0]};
    mem.raddr  = top_addr;
    case (state)
      B_IDLE: begin
        if (tok_valid) state_next = B_RD_TOP;
      end
      B_RD_TOP: begin
        state_next = B_RD_BOT;
      end
      B_RD_BOT: begin
        mem.raddr  = bot_addr;
        state_next = B_MUL;
      end
      B_MUL: begin
        state_next = B_SUM;
      end
      B_SUM: begin
        state_next = B_WR_TOP;
      end
      B_WR_TOP: begin
        mem.we     = 1'b1;
        state_next = B_WR_BOT;
      end
      B_WR_BOT: begin
        mem.we     = 1'b1;
        mem.waddr  = bot_addr;
        mem.wdata  = {bot_re[BIN_W-1:0], bot_im[BIN_W-1:0]};
        state_next = (bf_last && stage_last) ? B_UNLOAD : B_RD_TOP;
      end
      B_UNLOAD: begin
        mem.raddr = k;
        issue     = (occ < 2'd2);
        if (issue && (k == ADDR_W'(POINTS - 1))) state_next = B_DRAIN;
      end
      B_DRAIN: begin
        if (!inflight) begin
          frame_end  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      stage    <= '0;
      bf       <= '0;
      k        <= '0;
      inflight <= 1'b0;
      q_wp     <= 1'b0;
      q_rp     <= 1'b0;
      q_count  <= '0;
    end else begin
      state    <= state_next;
      inflight <= issue;
      case (state)
        B_IDLE: begin
          stage <= '0;
          bf    <= '0;
          k     <= '0;
        end
        B_WR_BOT: begin
          if (bf_last) begin
            bf <= '0;
            if (!stage_last) stage <= stage + 1'b1;
          end else begin
            bf <= bf + 1'b1;
          end
        end
        B_UNLOAD: begin
          if (issue) k <= k + 1'b1;
        end
        default: ;
      endcase
      if (inflight) q_wp <= ~q_wp;
      if (q_pop) q_rp <= ~q_rp;
      q_count <= q_count + {1'b0, inflight} - {1'b0, q_pop};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    inflight_last <= (k == ADDR_W'(POINTS - 1));
    if (state == B_IDLE) mode <= tok_mode;
    if (state == B_RD_BOT) begin
      a_re <= rd_re;
      a_im <= rd_im;
    end
    if (state == B_MUL) begin
      pr_rr <= rd_re * w_re;
      pr_ii <= rd_im * w_im;
      pr_ri <= rd_im * w_re;
      pr_ir <= rd_re * w_im;
    end
    if (state == B_SUM) begin
      z_re <= Z_W'(rnd_r >>> RND_BITS);
      z_im <= Z_W'(rnd_i >>> RND_BITS);
    end
    if (inflight) begin
      q_re[q_wp]   <= rd_re;
      q_im[q_wp]   <= rd_im;
      q_last[q_wp] <= inflight_last;
    end
  end

  assign empty    = (q_count == 2'd0);
  assign bin_re   = q_re[q_rp];
  assign bin_im   = q_im[q_rp];
  assign bin_last = q_last[q_rp];

endmodule

// ----- rtl/radix2_fft_forward_inverse_unit.sv -----
// the single butterfly unit works on one ram port pair, stepping each butterfly through
//   read top, read bottom, multiply, sum, write top and write bottom
// loading of the next frame overlaps the transform through two ram banks
// reset: synchronous, clears control, mode and frame position; ram contents are not cleared
`include "radix2_fft_forward_inverse_unit_assert.svh"
// ----------------------------------------------------------------------------
// radix2_fft_forward_inverse_unit
// frame loader, two-entry frame queue over two banks, butterfly engine
// ----------------------------------------------------------------------------
module radix2_fft_forward_inverse_unit import r2fft_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_re,
  input  logic signed [SAMPLE_W-1:0] sample_im,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [BIN_W-1:0]    bin_re,
  output logic signed [BIN_W-1:0]    bin_im,
  output logic                       bin_last,
  input  logic                       inverse_mode_we,
  input  logic                       inverse_mode_wdata
);

  logic        inverse_mode;
  front_wr_t   front_wr;
  back_mem_t   back_mem;
  logic        frame_done, frame_end;
  logic        tok_mode [2];
  logic        wr_bank, rd_bank;
  logic [1:0]  tok_count;
  logic [WORD_W-1:0] bank_rdata [2];

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (inverse_mode_we) begin
      inverse_mode <= inverse_mode_wdata;
    end
  end

  // frame queue: one entry per bank
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_bank   <= 1'b0;
      rd_bank   <= 1'b0;
      tok_count <= '0;
    end else begin
      if (frame_done) wr_bank <= ~wr_bank;
      if (frame_end) rd_bank <= ~rd_bank;
      tok_count <= tok_count + {1'b0, frame_done} - {1'b0, frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) tok_mode[wr_bank] <= inverse_mode;
  end

  assign full = (tok_count == 2'd2);

  r2fft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_re  (sample_re),
    .sample_im  (sample_im),
    .wr         (front_wr),
    .frame_done (frame_done)
  );

  // two banks, owned by the loader or the engine
  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic              sel_front;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;

    assign sel_front = front_wr.en && (wr_bank == 1'(b));
    assign we        = sel_front || (back_mem.we && (rd_bank == 1'(b)));
    assign waddr     = sel_front ? front_wr.addr : back_mem.waddr;
    assign wdata     = sel_front ? front_wr.data : back_mem.wdata;

    r2fft_ram #(
      .WIDTH (WORD_W),
      .DEPTH (POINTS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (back_mem.raddr),
      .rdata (bank_rdata[b])
    );
  end

  r2fft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_count != 2'd0),
    .tok_mode  (tok_mode[rd_bank]),
    .rdata     (bank_rdata[rd_bank]),
    .mem       (back_mem),
    .frame_end (frame_end),
    .pop       (pop),
    .empty     (empty),
    .bin_re    (bin_re),
    .bin_im    (bin_im),
    .bin_last  (bin_last)
  );

  // checks
  `R2FFT_NEVER(a_bank_clash, front_wr.en && back_mem.we && (wr_bank == rd_bank), "bank clash")
  `R2FFT_NEVER(a_queue_overflow, frame_done && (tok_count == 2'd2), "frame queue overflow")
  `R2FFT_IMPLIES(a_engine_has_frame, back_mem.we, tok_count != 2'd0, "write with no frame")

endmodule
